// ===== hdl/fsa_pkg.sv =====
// Types and constants shared by the fragmented sparse array.
package fsa_pkg;

    // Field widths of the input and result items.
    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 10;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ELEM_W   = 11;
    localparam int FRAG_W   = 5;
    localparam int LEN_W    = 7;
    localparam int CFG_IDX_W = 2;

    // Quotient bits the divider resolves in one cycle.
    localparam int DIV_STEPS = 5;

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_SET      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GET      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IS_SET   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CONTAINS = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_LEN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_MARKER = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_EXEC,
        S_ROW,
        S_CELL,
        S_DONE
    } t_state;

    // Per-operation part of a result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   value;
        logic                found;
    } t_result;

endpackage

// ===== hdl/fragmented_sparse_array_top.sv =====
// Fragmented sparse array with lazy fragment allocation, memory based.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_kind, i_index, i_key
//  out     | output    | o_out_valid / i_out_stall| o_status, o_value, o_found,
//          |           |                          | o_element_count, o_active_fragments
//  cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// Set, get, delete and is_set pass through the index divider (5 quotient
// bits per cycle), one registered read of the cell and occupancy memories,
// a modify and write-back step and a hand-off step. Contains walks each
// active fragment through the single read port of the cell memory; it
// stops at the first match. Clear and unknown kinds go straight to hand-off.
// Reset clears the fragment active bits and counters at once; there is no
// clearing pass. A finished result waits in the output register while the
// next item is taken; a stalled output holds the sequencer only at hand-off.
module fragmented_sparse_array_top
    import fsa_pkg::*;
#(
    parameter int MAX_FRAGMENTS    = 16,
    parameter int MAX_FRAGMENT_LEN = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input item channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [INDEX_W-1:0]   i_index,
    input  logic signed [DATA_W-1:0] i_key,
    // Result item channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic signed [DATA_W-1:0] o_value,
    output logic                 o_found,
    output logic [ELEM_W-1:0]    o_element_count,
    output logic [FRAG_W-1:0]    o_active_fragments,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int RW    = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int CW    = (MAX_FRAGMENT_LEN > 1) ? $clog2(MAX_FRAGMENT_LEN) : 1;
    localparam int DEPTH = MAX_FRAGMENTS * MAX_FRAGMENT_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer.
    t_state r_state, n_state;

    // Configuration registers.
    logic [FRAG_W-1:0] r_frag_count;
    logic [LEN_W-1:0]  r_frag_len;
    logic [DATA_W-1:0] r_marker;

    // Fragment bookkeeping.
    logic [MAX_FRAGMENTS-1:0] r_active;
    logic [ELEM_W-1:0]        r_elem_count;
    logic [FRAG_W-1:0]        r_act_count;

    // Item being processed.
    logic [KIND_W-1:0]  r_kind;
    logic [INDEX_W-1:0] r_index;
    logic [DATA_W-1:0]  r_key;
    t_result            r_res;

    // Index divider.
    logic [INDEX_W-1:0] r_div_q, n_div_q;
    logic [LEN_W-1:0]   r_div_rem, n_div_rem;
    logic               r_div_cnt;

    // Key search.
    logic [FRAG_W-1:0] r_scan_row;
    logic [LEN_W-1:0]  r_scan_col;
    logic              r_cmp_valid;
    logic [CW-1:0]     r_cmp_col;

    // Output register.
    logic              r_out_valid;
    t_result           r_out_res;
    logic [ELEM_W-1:0] r_out_elem;
    logic [FRAG_W-1:0] r_out_act;

    // Memories and their registered read data.
    logic [DATA_W-1:0]           r_cell_mem [DEPTH];
    logic [MAX_FRAGMENT_LEN-1:0] r_occ_mem  [MAX_FRAGMENTS];
    logic [DATA_W-1:0]           r_cell_q;
    logic [MAX_FRAGMENT_LEN-1:0] r_occ_q;

    logic                        in_accept;
    logic                        out_free;
    logic                        empty_all;
    logic [11:0]                 capacity;
    logic                        in_range;
    logic [RW-1:0]               row_sel;
    logic [CW-1:0]               col_sel;
    logic [RW-1:0]               scan_row_sel;
    logic [CW-1:0]               scan_col_sel;
    logic [AW-1:0]               cell_rd_addr;
    logic [AW-1:0]               cell_wr_addr;
    logic [RW-1:0]               occ_rd_row;
    logic [MAX_FRAGMENT_LEN-1:0] bit_mask;
    logic                        row_active;
    logic [MAX_FRAGMENT_LEN-1:0] mask_eff;
    logic                        occupied;
    logic                        hit;
    logic                        scan_issue;
    logic                        scan_end;
    logic [FRAG_W-1:0]           cfg_count;
    logic [LEN_W-1:0]            cfg_len;

    // Write-back controls from the execute step.
    logic                        cell_we;
    logic                        occ_we;
    logic [MAX_FRAGMENT_LEN-1:0] occ_wdata;
    logic                        set_active;
    logic                        clr_active;
    logic                        elem_inc;
    logic                        elem_dec;
    t_result                     exec_res;

    // Flat cell address of a fragment and an offset.
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(MAX_FRAGMENT_LEN) + AW'(col);
    endfunction

    // Handshake.
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // A geometry write or a clear transfer empties the array.
    assign empty_all = (i_cfg_we && ((i_cfg_index == CFG_FRAG_COUNT) ||
                                     (i_cfg_index == CFG_FRAG_LEN))) ||
                       (in_accept && (i_kind == KIND_CLEAR));

    // Register values, taken from the low data bits, are clamped into their legal ranges.
    always_comb begin
        if (i_cfg_data[FRAG_W-1:0] == '0) begin
            cfg_count = FRAG_W'(1);
        end else if (32'(i_cfg_data[FRAG_W-1:0]) > MAX_FRAGMENTS) begin
            cfg_count = FRAG_W'(MAX_FRAGMENTS);
        end else begin
            cfg_count = i_cfg_data[FRAG_W-1:0];
        end
        if (i_cfg_data[LEN_W-1:0] == '0) begin
            cfg_len = LEN_W'(1);
        end else if (32'(i_cfg_data[LEN_W-1:0]) > MAX_FRAGMENT_LEN) begin
            cfg_len = LEN_W'(MAX_FRAGMENT_LEN);
        end else begin
            cfg_len = i_cfg_data[LEN_W-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag_count <= (MAX_FRAGMENTS < 16) ? FRAG_W'(MAX_FRAGMENTS) : FRAG_W'(16);
            r_frag_len   <= LEN_W'(MAX_FRAGMENT_LEN);
            r_marker     <= 32'h8000_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAG_COUNT:    r_frag_count <= cfg_count;
                CFG_FRAG_LEN:      r_frag_len   <= cfg_len;
                CFG_UNUSED_MARKER: r_marker     <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Range check against the configured geometry.
    assign capacity = 12'(r_frag_count) * 12'(r_frag_len);
    assign in_range = (12'(r_index) < capacity);

    // Restoring division of the index by the fragment length.
    always_comb begin
        logic [INDEX_W-1:0] q;
        logic [LEN_W-1:0]   rem;
        q   = r_div_q;
        rem = r_div_rem;
        for (int s = 0; s < DIV_STEPS; s++) begin
            rem = {rem[LEN_W-2:0], q[INDEX_W-1]};
            q   = {q[INDEX_W-2:0], 1'b0};
            if (rem >= r_frag_len) begin
                rem  = rem - r_frag_len;
                q[0] = 1'b1;
            end
        end
        n_div_q   = q;
        n_div_rem = rem;
    end

    // Fragment and offset of the item, and of the search position.
    assign row_sel      = RW'(r_div_q);
    assign col_sel      = CW'(r_div_rem);
    assign scan_row_sel = RW'(r_scan_row);
    assign scan_col_sel = CW'(r_scan_col);

    // Memory read addresses.
    assign cell_rd_addr = (r_state == S_CELL) ? cell_addr(scan_row_sel, scan_col_sel)
                                              : cell_addr(row_sel, col_sel);
    assign cell_wr_addr = cell_addr(row_sel, col_sel);
    assign occ_rd_row   = ((r_state == S_ROW) || (r_state == S_CELL)) ? scan_row_sel
                                                                       : row_sel;

    // An inactive fragment reads as an empty occupancy row.
    assign bit_mask   = MAX_FRAGMENT_LEN'(1'b1) << col_sel;
    assign row_active = in_range && r_active[row_sel];
    assign mask_eff   = row_active ? r_occ_q : '0;
    assign occupied   = in_range && mask_eff[col_sel];

    // Execute step: result and write-back for the indexed kinds.
    always_comb begin
        exec_res   = '{status: STATUS_OK, value: '0, found: 1'b0};
        cell_we    = 1'b0;
        occ_we     = 1'b0;
        occ_wdata  = mask_eff;
        set_active = 1'b0;
        clr_active = 1'b0;
        elem_inc   = 1'b0;
        elem_dec   = 1'b0;
        if ((r_kind inside {[KIND_SET:KIND_IS_SET]}) && !in_range) begin
            exec_res.status = STATUS_RANGE;
            if (r_kind == KIND_GET) begin
                exec_res.value = r_marker;
            end
        end else begin
            case (r_kind)
                KIND_SET: begin
                    cell_we    = 1'b1;
                    occ_we     = 1'b1;
                    occ_wdata  = mask_eff | bit_mask;
                    set_active = !row_active;
                    elem_inc   = !occupied;
                end
                KIND_GET: begin
                    exec_res.value = occupied ? r_cell_q : r_marker;
                end
                KIND_DELETE: begin
                    if (!occupied) begin
                        exec_res.status = STATUS_EMPTY;
                    end else begin
                        occ_we     = 1'b1;
                        occ_wdata  = mask_eff & ~bit_mask;
                        elem_dec   = 1'b1;
                        clr_active = ((mask_eff & ~bit_mask) == '0);
                    end
                end
                KIND_IS_SET: begin
                    exec_res.found = occupied;
                end
                default: ;
            endcase
        end
    end

    // Key search: compare the cell read in the previous cycle.
    assign hit        = r_cmp_valid && r_occ_q[r_cmp_col] && (r_cell_q == r_key);
    assign scan_issue = (r_state == S_CELL) && !hit && (r_scan_col < r_frag_len);
    assign scan_end   = (r_state == S_CELL) && !hit && (r_scan_col >= r_frag_len);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_kind inside {[KIND_SET:KIND_IS_SET]}) begin
                        n_state = S_DIV;
                    end else if (i_kind == KIND_CONTAINS) begin
                        n_state = S_ROW;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (r_div_cnt) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: n_state = S_DONE;
            S_ROW: begin
                if (r_scan_row >= r_frag_count) begin
                    n_state = S_DONE;
                end else if (r_active[scan_row_sel]) begin
                    n_state = S_CELL;
                end
            end
            S_CELL: begin
                if (hit) begin
                    n_state = S_DONE;
                end else if (scan_end) begin
                    n_state = S_ROW;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Fragment active bits and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_elem_count <= '0;
            r_act_count  <= '0;
        end else if (empty_all) begin
            r_active     <= '0;
            r_elem_count <= '0;
            r_act_count  <= '0;
        end else if (r_state == S_EXEC) begin
            if (set_active) begin
                r_active[row_sel] <= 1'b1;
                r_act_count       <= r_act_count + FRAG_W'(1);
            end else if (clr_active) begin
                r_active[row_sel] <= 1'b0;
                r_act_count       <= r_act_count - FRAG_W'(1);
            end
            if (elem_inc) begin
                r_elem_count <= r_elem_count + ELEM_W'(1);
            end else if (elem_dec) begin
                r_elem_count <= r_elem_count - ELEM_W'(1);
            end
        end
    end

    // Item registers, divider and search position.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind     <= i_kind;
            r_index    <= i_index;
            r_key      <= i_key;
            r_res      <= '{status: STATUS_OK, value: '0, found: 1'b0};
            r_div_q    <= i_index;
            r_div_rem  <= '0;
            r_div_cnt  <= 1'b0;
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else begin
            case (r_state)
                S_DIV: begin
                    r_div_q   <= n_div_q;
                    r_div_rem <= n_div_rem;
                    r_div_cnt <= ~r_div_cnt;
                end
                S_EXEC: r_res <= exec_res;
                S_ROW: begin
                    if ((r_scan_row < r_frag_count) && !r_active[scan_row_sel]) begin
                        r_scan_row <= r_scan_row + FRAG_W'(1);
                    end
                end
                S_CELL: begin
                    if (hit) begin
                        r_res.found <= 1'b1;
                    end else if (scan_issue) begin
                        r_scan_col <= r_scan_col + LEN_W'(1);
                    end else begin
                        r_scan_row <= r_scan_row + FRAG_W'(1);
                        r_scan_col <= '0;
                    end
                end
                default: ;
            endcase
        end
        r_cmp_col <= scan_col_sel;
    end

    // The compare stage is valid in the cycle after a search read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= scan_issue;
        end
    end

    // Cell memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && cell_we) begin
            r_cell_mem[cell_wr_addr] <= r_key;
        end
        r_cell_q <= r_cell_mem[cell_rd_addr];
    end

    // Occupancy memory: one row per fragment, valid only while it is active.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && occ_we) begin
            r_occ_mem[row_sel] <= occ_wdata;
        end
        r_occ_q <= r_occ_mem[occ_rd_row];
    end

    // Output register: loaded at hand-off, emptied by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_res  <= r_res;
            r_out_elem <= r_elem_count;
            r_out_act  <= r_act_count;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_res.status;
    assign o_value            = r_out_res.value;
    assign o_found            = r_out_res.found;
    assign o_element_count    = r_out_elem;
    assign o_active_fragments = r_out_act;

endmodule
